@@ rtl/mst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_pkg
// Shared types and codes for the multi-slot interval timer: action codes,
// slot modes, status codes, controller states and the cell interface structs.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Default number of timer slots
  localparam int SLOTS_DEF = 16;

  // Field widths fixed by the interface
  localparam int ACT_W    = 3;
  localparam int SLOT_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 3;

  // Action codes; 6 and 7 are unused and rejected as invalid
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK    = 3'd0,
    ACT_CREATE  = 3'd1,
    ACT_CANCEL  = 3'd2,
    ACT_RELEASE = 3'd3,
    ACT_STOP    = 3'd4,
    ACT_RESUME  = 3'd5
  } action_t;

  // Slot modes
  typedef enum logic [1:0] {
    MODE_RUN    = 2'd0,
    MODE_OVER   = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_CANCEL_REF  = 3'd4,
    ST_STOP_REF    = 3'd5,
    ST_RESUME_REF  = 3'd6,
    ST_NOT_FINISH  = 3'd7
  } status_t;

  // Result kinds
  localparam logic KIND_RESP   = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_TARGET,
    S_WALK,
    S_RESP
  } state_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [PERIOD_W-1:0] period;
    logic                rep;
    logic [TAG_W-1:0]    tag;
    logic                tgt_en;
  } cell_ctl_t;

  // Per-cell status back to the controller
  typedef struct packed {
    logic             used;
    mode_t            mode;
    logic             claim;
    logic             expire;
    logic [TAG_W-1:0] exp_tag;
  } cell_stat_t;

endpackage

@@ rtl/multi_slot_interval_timer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_interval_timer_top
// Table of SLOTS timer slots built as a chain of cells with a small command
// controller.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Cancel, release,
// stop, resume and any rejected command keep busy high for one cycle and give
// their single result in the cycle after that. A tick sends a token down the
// chain one slot per cycle and keeps busy high until it issues its closing
// beat; each expiring slot gives one expiry beat while the token passes it,
// and the closing beat marked last follows the walk. A create walks the same
// token until the first free slot, so how long busy stays high is set by the
// position of that slot. Results appear on out_valid for a single cycle and
// cannot be held off; the next command may be issued while the last beat
// of the previous one is on the outputs.
// ----------------------------------------------------------------------------
module multi_slot_interval_timer_top #(
  parameter int SLOTS = mst_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [mst_pkg::ACT_W-1:0]     in_action,
  input  logic [mst_pkg::SLOT_W-1:0]    in_slot,
  input  logic [mst_pkg::PERIOD_W-1:0]  in_period,
  input  logic                          in_repeat_req,
  input  logic [mst_pkg::TAG_W-1:0]     in_tag,
  // results
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [mst_pkg::STATUS_W-1:0]  out_status,
  output logic [mst_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [mst_pkg::TAG_W-1:0]     out_tag_out,
  output logic                          out_last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [mst_pkg::SLOT_W-1:0] SLOT_LIM = mst_pkg::SLOT_W'(SLOTS);

  mst_pkg::state_t              state_r, state_nxt;
  logic [mst_pkg::ACT_W-1:0]    act_r;
  logic [mst_pkg::SLOT_W-1:0]   slot_r;
  logic [mst_pkg::PERIOD_W-1:0] period_r;
  logic                         rep_r;
  logic [mst_pkg::TAG_W-1:0]    tag_r;
  logic [IDX_W-1:0]             walk_idx_r, walk_idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_kind_r, out_kind_nxt;
  mst_pkg::status_t             out_status_r, out_status_nxt;
  logic [mst_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [mst_pkg::TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         accept;
  logic                         launch;
  logic                         tgt_ok;
  mst_pkg::cell_ctl_t           ctl;
  logic [SLOTS:0]               tok_link;
  logic [SLOTS-1:0]             hit;
  mst_pkg::cell_stat_t          stat [SLOTS];

  logic                         sel_used;
  logic [1:0]                   sel_mode_bits;
  mst_pkg::mode_t               sel_mode;
  logic                         any_claim;
  logic                         any_expire;
  logic [mst_pkg::TAG_W-1:0]    exp_tag;
  mst_pkg::status_t             tgt_status;

  assign busy   = (state_r != mst_pkg::S_IDLE);
  assign accept = start && !busy;

  // Walk commands: tick, and create with a nonzero period
  assign launch = accept && ((in_action == mst_pkg::ACT_TICK) ||
                  ((in_action == mst_pkg::ACT_CREATE) && (in_period != '0)));

  // Direct command with a legal action and slot
  assign tgt_ok = (act_r == mst_pkg::ACT_CANCEL || act_r == mst_pkg::ACT_RELEASE ||
                   act_r == mst_pkg::ACT_STOP   || act_r == mst_pkg::ACT_RESUME) &&
                  (slot_r < SLOT_LIM);

  // Command broadcast
  assign ctl.action = act_r;
  assign ctl.period = period_r;
  assign ctl.rep    = rep_r;
  assign ctl.tag    = tag_r;
  assign ctl.tgt_en = (state_r == mst_pkg::S_TARGET) && tgt_ok;

  // Cell chain
  assign tok_link[0] = launch;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign hit[i] = (slot_r == mst_pkg::SLOT_W'(i));

    mst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tgt_hit (hit[i]),
      .tok_in  (tok_link[i]),
      .tok_out (tok_link[i+1]),
      .stat    (stat[i])
    );
  end

  // Gather: target slot select and token-cell events
  always_comb begin
    sel_used      = 1'b0;
    sel_mode_bits = '0;
    any_claim     = 1'b0;
    any_expire    = 1'b0;
    exp_tag       = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sel_used      = sel_used | (hit[i] & stat[i].used);
      sel_mode_bits = sel_mode_bits | (hit[i] ? stat[i].mode : 2'b00);
      any_claim     = any_claim | stat[i].claim;
      any_expire    = any_expire | stat[i].expire;
      exp_tag       = exp_tag | stat[i].exp_tag;
    end
  end

  assign sel_mode = mst_pkg::mode_t'(sel_mode_bits);

  // Status of a direct or rejected command
  always_comb begin
    tgt_status = mst_pkg::ST_OK;
    if (act_r == mst_pkg::ACT_CREATE || !tgt_ok) begin
      tgt_status = mst_pkg::ST_INVALID;
    end else if (!sel_used) begin
      tgt_status = mst_pkg::ST_EMPTY;
    end else begin
      unique case (act_r)
        mst_pkg::ACT_CANCEL:
          if (sel_mode != mst_pkg::MODE_RUN) tgt_status = mst_pkg::ST_CANCEL_REF;
        mst_pkg::ACT_RELEASE:
          if (sel_mode != mst_pkg::MODE_OVER && sel_mode != mst_pkg::MODE_CANCEL)
            tgt_status = mst_pkg::ST_NOT_FINISH;
        mst_pkg::ACT_STOP:
          if (sel_mode != mst_pkg::MODE_RUN) tgt_status = mst_pkg::ST_STOP_REF;
        mst_pkg::ACT_RESUME:
          if (sel_mode != mst_pkg::MODE_STOP) tgt_status = mst_pkg::ST_RESUME_REF;
        default: tgt_status = mst_pkg::ST_INVALID;
      endcase
    end
  end

  // Controller: next state and result beats
  always_comb begin
    state_nxt      = state_r;
    walk_idx_nxt   = walk_idx_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      mst_pkg::S_IDLE: begin
        walk_idx_nxt = '0;
        if (accept) state_nxt = launch ? mst_pkg::S_WALK : mst_pkg::S_TARGET;
      end

      mst_pkg::S_TARGET: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = mst_pkg::KIND_RESP;
        out_status_nxt = tgt_status;
        out_slot_nxt   = slot_r;
        out_tag_nxt    = '0;
        out_last_nxt   = 1'b1;
        state_nxt      = mst_pkg::S_IDLE;
      end

      mst_pkg::S_WALK: begin
        walk_idx_nxt = walk_idx_r + IDX_W'(1);
        if (act_r == mst_pkg::ACT_CREATE) begin
          // create: stop at the claimed slot or report a full table
          if (any_claim) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = mst_pkg::KIND_RESP;
            out_status_nxt = mst_pkg::ST_OK;
            out_slot_nxt   = mst_pkg::SLOT_W'(walk_idx_r);
            out_tag_nxt    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = mst_pkg::S_IDLE;
          end else if (tok_link[SLOTS]) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = mst_pkg::KIND_RESP;
            out_status_nxt = mst_pkg::ST_NO_FREE;
            out_slot_nxt   = slot_r;
            out_tag_nxt    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = mst_pkg::S_IDLE;
          end
        end else begin
          // tick: one expiry beat per expiring slot
          if (any_expire) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = mst_pkg::KIND_EXPIRY;
            out_status_nxt = mst_pkg::ST_OK;
            out_slot_nxt   = mst_pkg::SLOT_W'(walk_idx_r);
            out_tag_nxt    = exp_tag;
            out_last_nxt   = 1'b0;
          end
          if (tok_link[SLOTS]) state_nxt = mst_pkg::S_RESP;
        end
      end

      mst_pkg::S_RESP: begin
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = mst_pkg::KIND_RESP;
        out_status_nxt = mst_pkg::ST_OK;
        out_slot_nxt   = slot_r;
        out_tag_nxt    = '0;
        out_last_nxt   = 1'b1;
        state_nxt      = mst_pkg::S_IDLE;
      end

      default: state_nxt = mst_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mst_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command capture, walk index and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      slot_r   <= in_slot;
      period_r <= in_period;
      rep_r    <= in_repeat_req;
      tag_r    <= in_tag;
    end
    walk_idx_r   <= walk_idx_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_slot_out = out_slot_r;
  assign out_tag_out  = out_tag_r;
  assign out_last     = out_last_r;

endmodule

@@ rtl/mst_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_cell
// One timer slot. Holds the slot's mode, countdown, period, repeat flag and
// tag. A walk token enters from the left neighbor and leaves to the right;
// while it holds the token the cell services a tick or a create. Direct
// commands (cancel, release, stop, resume) act on the selected cell at once.
// ----------------------------------------------------------------------------
module mst_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mst_pkg::cell_ctl_t      ctl,
  input  logic                    tgt_hit,
  input  logic                    tok_in,
  output logic                    tok_out,
  output mst_pkg::cell_stat_t     stat
);

  logic                         used_r, used_nxt;
  logic                         tok_r;
  mst_pkg::mode_t               mode_r, mode_nxt;
  logic [mst_pkg::PERIOD_W-1:0] cd_r, cd_nxt;
  logic [mst_pkg::PERIOD_W-1:0] reload_r, reload_nxt;
  logic                         rep_r, rep_nxt;
  logic [mst_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic                         claim;
  logic                         expire;

  // Token moves one cell per cycle; a create stops it at the first free cell
  assign claim   = tok_r && (ctl.action == mst_pkg::ACT_CREATE) && !used_r;
  assign tok_out = tok_r && !claim;

  // Slot update
  always_comb begin
    used_nxt   = used_r;
    mode_nxt   = mode_r;
    cd_nxt     = cd_r;
    reload_nxt = reload_r;
    rep_nxt    = rep_r;
    tag_nxt    = tag_r;
    expire     = 1'b0;

    // tick: count a running slot down, expire at one or below
    if (tok_r && (ctl.action == mst_pkg::ACT_TICK) && used_r &&
        (mode_r == mst_pkg::MODE_RUN)) begin
      if (cd_r <= mst_pkg::PERIOD_W'(1)) begin
        expire = 1'b1;
        if (rep_r) begin
          cd_nxt = reload_r;
        end else begin
          cd_nxt   = '0;
          mode_nxt = mst_pkg::MODE_OVER;
        end
      end else begin
        cd_nxt = cd_r - mst_pkg::PERIOD_W'(1);
      end
    end

    // create: claim this free slot
    if (claim) begin
      used_nxt   = 1'b1;
      mode_nxt   = mst_pkg::MODE_RUN;
      cd_nxt     = ctl.period;
      reload_nxt = ctl.period;
      rep_nxt    = ctl.rep;
      tag_nxt    = ctl.tag;
    end

    // direct commands on an occupied slot
    if (ctl.tgt_en && tgt_hit && used_r) begin
      unique case (ctl.action)
        mst_pkg::ACT_CANCEL: begin
          if (mode_r == mst_pkg::MODE_RUN) mode_nxt = mst_pkg::MODE_CANCEL;
        end
        mst_pkg::ACT_RELEASE: begin
          if (mode_r == mst_pkg::MODE_OVER || mode_r == mst_pkg::MODE_CANCEL)
            used_nxt = 1'b0;
        end
        mst_pkg::ACT_STOP: begin
          if (mode_r == mst_pkg::MODE_RUN) mode_nxt = mst_pkg::MODE_STOP;
        end
        mst_pkg::ACT_RESUME: begin
          if (mode_r == mst_pkg::MODE_STOP) mode_nxt = mst_pkg::MODE_RUN;
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_in;
    end
  end

  // Slot payload, valid only while used
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    cd_r     <= cd_nxt;
    reload_r <= reload_nxt;
    rep_r    <= rep_nxt;
    tag_r    <= tag_nxt;
  end

  // Status; token-gated fields so the controller can OR across cells
  assign stat.used    = used_r;
  assign stat.mode    = mode_r;
  assign stat.claim   = claim;
  assign stat.expire  = expire;
  assign stat.exp_tag = tok_r ? tag_r : '0;

endmodule

@@ rtl/mst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_checker
// Port-level checks for the multi-slot interval timer: beat ordering and
// result field consistency. Bound to the top level.
// ----------------------------------------------------------------------------
module mst_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         out_valid,
  input  logic                         out_kind,
  input  logic [mst_pkg::STATUS_W-1:0] out_status,
  input  logic [mst_pkg::TAG_W-1:0]    out_tag_out,
  input  logic                         out_last
);

  // Expiry beats are never last and always carry status ok
  a_expiry_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == mst_pkg::KIND_EXPIRY) |->
      (!out_last && out_status == mst_pkg::ST_OK))
    else $error("expiry beat with last set or bad status");

  // An expiry beat comes from a walk that still has its closing beat to give
  a_expiry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == mst_pkg::KIND_EXPIRY) |-> busy)
    else $error("expiry beat outside a tick walk");

  // Response beats carry a zero tag and close the command
  a_resp_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == mst_pkg::KIND_RESP) |-> (out_tag_out == '0 && out_last))
    else $error("response beat with tag or without last");

  // A taken command has busy high in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken without a busy cycle");

  // No beat follows the last beat back to back
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("beat directly after last beat");

endmodule

bind multi_slot_interval_timer_top mst_checker u_mst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_kind    (out_kind),
  .out_status  (out_status),
  .out_tag_out (out_tag_out),
  .out_last    (out_last)
);

@@ bench/tb_multi_slot_interval_timer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_slot_interval_timer_top
// Self-checking bench for the timer slot table. A directed table hits the
// field extremes, every action and each refusal code but ST_NO_FREE. A long random run then
// fills, churns and drains the table. A cycle-free model of the table
// predicts every result beat, and each beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_multi_slot_interval_timer_top;
  import mst_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int RAND_ITEMS = 345;
  localparam int IDLE_LIMIT = 2000;
  localparam int DIR_N      = 25;

  // Action codes the block must reject
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

  // One result beat as the block should produce it
  typedef struct packed {
    logic              kind;
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_beat_t;

  // Directed row; pinned rows carry the status and slot of their last beat
  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                rep;
    logic [TAG_W-1:0]    tag;
    logic                pinned;
    status_t             pin_status;
    logic [SLOT_W-1:0]   pin_slot;
  } dir_row_t;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    // empty table: tick gives only its closing beat
    '{ACT_TICK,      8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_OK,         8'h00},
    '{ACT_CANCEL,    8'h03, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_EMPTY,      8'h03},
    // out-of-range slots and unused actions
    '{ACT_RELEASE,   8'hFF, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_INVALID,    8'hFF},
    '{ACT_STOP,      8'h10, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_INVALID,    8'h10},
    '{ACT_UNUSED_LO, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_INVALID,    8'h00},
    '{ACT_UNUSED_HI, 8'h80, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, ST_INVALID,    8'h80},
    // zero period, then three creates, two of them at the period extremes
    '{ACT_CREATE,    8'hAA, 16'h0000, 1'b1, 16'h5555, 1'b1, ST_INVALID,    8'hAA},
    '{ACT_CREATE,    8'hFF, 16'h0001, 1'b0, 16'hFFFF, 1'b1, ST_OK,         8'h00},
    '{ACT_CREATE,    8'h00, 16'hFFFF, 1'b1, 16'h0000, 1'b1, ST_OK,         8'h01},
    '{ACT_CREATE,    8'h55, 16'h0002, 1'b1, 16'h1234, 1'b1, ST_OK,         8'h02},
    // slot 0 expires one-shot
    '{ACT_TICK,      8'h5A, 16'h0000, 1'b0, 16'h0000, 1'b0, ST_OK,         8'h00},
    // refusals on an expired slot
    '{ACT_CANCEL,    8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_CANCEL_REF, 8'h00},
    '{ACT_STOP,      8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_STOP_REF,   8'h00},
    '{ACT_RESUME,    8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_RESUME_REF, 8'h00},
    // release of running and stopped slots is not finished
    '{ACT_RELEASE,   8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_NOT_FINISH, 8'h01},
    '{ACT_STOP,      8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_OK,         8'h01},
    '{ACT_RELEASE,   8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_NOT_FINISH, 8'h01},
    '{ACT_RESUME,    8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_OK,         8'h01},
    '{ACT_CANCEL,    8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_OK,         8'h01},
    '{ACT_RELEASE,   8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_OK,         8'h01},
    '{ACT_RELEASE,   8'h01, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_EMPTY,      8'h01},
    '{ACT_RELEASE,   8'h00, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_OK,         8'h00},
    '{ACT_RESUME,    8'h0F, 16'h0000, 1'b0, 16'h0000, 1'b1, ST_EMPTY,      8'h0F},
    // repeating slot 2 expires and reloads, then counts down
    '{ACT_TICK,      8'hFF, 16'h0000, 1'b0, 16'h0000, 1'b0, ST_OK,         8'h00},
    '{ACT_TICK,      8'h01, 16'h0000, 1'b0, 16'h0000, 1'b0, ST_OK,         8'h00}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [ACT_W-1:0]    in_action = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [PERIOD_W-1:0] in_period = '0;
  logic                in_repeat_req = 1'b0;
  logic [TAG_W-1:0]    in_tag = '0;
  logic                out_valid;
  logic                out_kind;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot_out;
  logic [TAG_W-1:0]    out_tag_out;
  logic                out_last;

  // Pinned expectation travels alongside the command
  logic                cmd_pinned = 1'b0;
  status_t             cmd_pin_status = ST_OK;
  logic [SLOT_W-1:0]   cmd_pin_slot = '0;

  // Shadow copy of the slot table
  logic                slot_used     [SLOTS];
  mode_t               slot_mode     [SLOTS];
  logic [PERIOD_W-1:0] countdown     [SLOTS];
  logic [PERIOD_W-1:0] reload_period [SLOTS];
  logic                repeat_mark   [SLOTS];
  logic [TAG_W-1:0]    user_tag      [SLOTS];

  timer_beat_t pending_beats[$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  multi_slot_interval_timer_top #(.SLOTS(SLOTS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_slot      (in_slot),
    .in_period    (in_period),
    .in_repeat_req(in_repeat_req),
    .in_tag       (in_tag),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .out_tag_out  (out_tag_out),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow table and queue the beats it causes
  function automatic void predict_timer_beats(input logic [ACT_W-1:0] act,
                                              input logic [SLOT_W-1:0] slot,
                                              input logic [PERIOD_W-1:0] period,
                                              input logic rep,
                                              input logic [TAG_W-1:0] tag);
    status_t           st;
    logic [SLOT_W-1:0] res_slot;
    bit                found;
    st       = ST_OK;
    res_slot = slot;
    found    = 1'b0;
    if (act == ACT_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_mode[i] == MODE_RUN) begin
          if (countdown[i] <= 1) begin
            pending_beats.push_back('{KIND_EXPIRY, ST_OK, 8'(i), user_tag[i], 1'b0});
            if (repeat_mark[i]) begin
              countdown[i] = reload_period[i];
            end else begin
              countdown[i] = '0;
              slot_mode[i] = MODE_OVER;
            end
          end else begin
            countdown[i] = countdown[i] - 1'b1;
          end
        end
      end
    end else if (act == ACT_CREATE) begin
      if (period == '0) begin
        st = ST_INVALID;
      end else begin
        st = ST_NO_FREE;
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && !slot_used[i]) begin
            found            = 1'b1;
            slot_used[i]     = 1'b1;
            slot_mode[i]     = MODE_RUN;
            countdown[i]     = period;
            reload_period[i] = period;
            repeat_mark[i]   = rep;
            user_tag[i]      = tag;
            st               = ST_OK;
            res_slot         = 8'(i);
          end
        end
      end
    end else if (act > ACT_RESUME || slot >= SLOTS) begin
      st = ST_INVALID;
    end else if (!slot_used[slot]) begin
      st = ST_EMPTY;
    end else begin
      case (act)
        ACT_CANCEL: begin
          if (slot_mode[slot] == MODE_RUN) slot_mode[slot] = MODE_CANCEL;
          else st = ST_CANCEL_REF;
        end
        ACT_RELEASE: begin
          if (slot_mode[slot] == MODE_OVER || slot_mode[slot] == MODE_CANCEL)
            slot_used[slot] = 1'b0;
          else st = ST_NOT_FINISH;
        end
        ACT_STOP: begin
          if (slot_mode[slot] == MODE_RUN) slot_mode[slot] = MODE_STOP;
          else st = ST_STOP_REF;
        end
        default: begin
          if (slot_mode[slot] == MODE_STOP) slot_mode[slot] = MODE_RUN;
          else st = ST_RESUME_REF;
        end
      endcase
    end
    // closing beat, with tick echoing its slot
    pending_beats.push_back('{KIND_RESP, st, res_slot, 16'h0000, 1'b1});
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Present one command after a random gap and hold it until taken
  task automatic issue_cmd(input logic [ACT_W-1:0] act, input logic [SLOT_W-1:0] slot,
                           input logic [PERIOD_W-1:0] period, input logic rep,
                           input logic [TAG_W-1:0] tag, input logic pinned,
                           input status_t pin_status, input logic [SLOT_W-1:0] pin_slot);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_slot        <= slot;
    in_period      <= period;
    in_repeat_req  <= rep;
    in_tag         <= tag;
    cmd_pinned     <= pinned;
    cmd_pin_status <= pin_status;
    cmd_pin_slot   <= pin_slot;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Scoreboard: compare result beats, then predict for a command taken now
  always @(posedge clk) begin
    timer_beat_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_beats.size() == 0) begin
          $error("unexpected result beat: kind %0d slot %0d", out_kind, out_slot_out);
          err_cnt++;
        end else begin
          want = pending_beats.pop_front();
          check_field("kind", 16'(want.kind), 16'(out_kind));
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("slot_out", 16'(want.slot), 16'(out_slot_out));
          check_field("tag_out", want.tag, out_tag_out);
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (start && busy === 1'b0) begin
        predict_timer_beats(in_action, in_slot, in_period, in_repeat_req, in_tag);
        if (cmd_pinned) begin
          want = pending_beats.pop_back();
          want.status = cmd_pin_status;
          want.slot   = cmd_pin_slot;
          pending_beats.push_back(want);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    mix_t                mix;
    logic [ACT_W-1:0]    r_act;
    logic [SLOT_W-1:0]   r_slot;
    logic [PERIOD_W-1:0] r_period;
    logic                r_rep;
    logic [TAG_W-1:0]    r_tag;
    int                  roll;
    int                  create_pct;
    int                  tick_pct;
    mix = MIX_FILL;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_N; r++) begin
      issue_cmd(DIR_ROWS[r].act, DIR_ROWS[r].slot, DIR_ROWS[r].period, DIR_ROWS[r].rep,
                DIR_ROWS[r].tag, DIR_ROWS[r].pinned, DIR_ROWS[r].pin_status,
                DIR_ROWS[r].pin_slot);
    end

    // random epochs: fill the table, churn it, drain it
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 30 == 0) begin
        mix     = mix_t'($urandom_range(0, 2));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      case (mix)
        MIX_FILL:  begin create_pct = 50; tick_pct = 20; end
        MIX_CHURN: begin create_pct = 25; tick_pct = 35; end
        default:   begin create_pct = 8;  tick_pct = 45; end
      endcase
      r_rep = 1'($urandom_range(0, 1));
      r_tag = 16'($urandom);
      roll  = $urandom_range(0, 19);
      // mostly short periods so slots expire often
      if (roll == 0) r_period = 16'($urandom);
      else if (roll < 3) r_period = 16'($urandom_range(1, 400));
      else r_period = 16'($urandom_range(1, 6));
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any action code, any slot
        r_act  = 3'($urandom_range(0, 7));
        r_slot = 8'($urandom_range(0, 255));
      end else begin
        roll   = $urandom_range(0, 99);
        r_slot = 8'($urandom_range(0, SLOTS - 1));
        if (roll < create_pct) begin
          r_act  = ACT_CREATE;
          r_slot = 8'($urandom_range(0, 255));
        end else if (roll < create_pct + tick_pct) begin
          r_act  = ACT_TICK;
          r_slot = 8'($urandom_range(0, 255));
        end else begin
          case ($urandom_range(0, 3))
            0:       r_act = ACT_CANCEL;
            1:       r_act = ACT_RELEASE;
            2:       r_act = ACT_STOP;
            default: r_act = ACT_RESUME;
          endcase
        end
      end
      issue_cmd(r_act, r_slot, r_period, r_rep, r_tag, 1'b0, ST_OK, 8'h00);
    end
    start <= 1'b0;

    // drain outstanding beats, then allow for stray ones
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    // every predicted beat must have shown up
    if (pending_beats.size() != 0) begin
      $error("result beats missing: %0d still expected", pending_beats.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
